// ----- sv/sls_pkg.sv -----
// shared codes, lamp constants and config type for the status led sequencer
package sls_pkg;

  localparam int SLS_LED_COUNT  = 6;
  localparam int SLS_TICK_WIDTH = 32;

  localparam int LAMP_COUNT = 6;
  localparam int OP_W       = 3;
  localparam int MODE_W     = 3;
  localparam int NOW_W      = 32;
  localparam int CFG_W      = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // input op codes
  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_ADV        = 3'd1;
  localparam logic [OP_W-1:0] OP_CONNECT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DATA       = 3'd3;
  localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd4;
  localparam logic [OP_W-1:0] OP_UPD_START  = 3'd5;
  localparam logic [OP_W-1:0] OP_UPD_DONE   = 3'd6;

  // mode codes
  localparam logic [MODE_W-1:0] M_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] M_ADV    = 3'd1;
  localparam logic [MODE_W-1:0] M_SWEEP  = 3'd2;
  localparam logic [MODE_W-1:0] M_CONN   = 3'd3;
  localparam logic [MODE_W-1:0] M_DATA   = 3'd4;
  localparam logic [MODE_W-1:0] M_UPDATE = 3'd5;

  // register indexes
  localparam logic [1:0] REG_SWEEP_ON  = 2'd0;
  localparam logic [1:0] REG_SWEEP_GAP = 2'd1;
  localparam logic [1:0] REG_ADV_HALF  = 2'd2;
  localparam logic [1:0] REG_DATA_OFF  = 2'd3;

  localparam logic [LAMP_COUNT-1:0] PWR_BIT    = 6'h02;
  localparam logic [LAMP_COUNT-1:0] BT_BIT     = 6'h08;
  localparam logic [LAMP_COUNT-1:0] LCP1_BIT   = 6'h10;
  localparam logic [LAMP_COUNT-1:0] LCP2_BIT   = 6'h20;
  localparam logic [LAMP_COUNT-1:0] ADV_LAMPS  = PWR_BIT | LCP1_BIT;
  localparam logic [LAMP_COUNT-1:0] CONN_LAMPS = PWR_BIT | BT_BIT | LCP1_BIT | LCP2_BIT;
  localparam logic [LAMP_COUNT-1:0] INIT_LAMPS = PWR_BIT | LCP1_BIT | LCP2_BIT;

  localparam logic [CFG_W-1:0] RST_SWEEP_ON  = 16'd80;
  localparam logic [CFG_W-1:0] RST_SWEEP_GAP = 16'd30;
  localparam logic [CFG_W-1:0] RST_ADV_HALF  = 16'd500;
  localparam logic [CFG_W-1:0] RST_DATA_OFF  = 16'd80;

  typedef struct packed {
    logic [CFG_W-1:0] sweep_on;
    logic [CFG_W-1:0] sweep_gap;
    logic [CFG_W-1:0] adv_half;
    logic [CFG_W-1:0] data_off;
  } sls_cfg_t;

endpackage

// ----- sv/status_led_sequencer.sv -----
// top level of the status led sequencer: config registers, input and result registers
//
//  channel   ports                                  accepted when
//  in        in_valid, in_stall, in_op, in_now      in_valid && !in_stall
//  out       out_valid, out_stall, out_led_pattern,  out_valid && !out_stall
//            out_mode
//  config    psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//            prdata, pready
//
// one word per cycle sustained while out_stall is low; each word is held in the input
// register and its result is then registered in the output register.
// reset puts the block in idle with pwr, lcp1 and lcp2 lit and loads the default
// tick counts. a stalled result holds the output register; in_stall rises only when
// the input register is full and the output register is full and stalled.
module status_led_sequencer import sls_pkg::*; #(
  parameter int LedCount  = SLS_LED_COUNT,
  parameter int TickWidth = SLS_TICK_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [NOW_W-1:0]      in_now,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LAMP_COUNT-1:0] out_led_pattern,
  output logic [MODE_W-1:0]     out_mode,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int PosW = $clog2(LedCount);

  sls_cfg_t              cfg_r;
  logic                  s1_valid_r;
  logic [OP_W-1:0]       s1_op_r;
  logic [NOW_W-1:0]      s1_now_r;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [LAMP_COUNT-1:0] lamps_r, lamps_nxt;
  logic [TickWidth-1:0]  deadline_r, deadline_nxt;
  logic [PosW-1:0]       sweep_pos_r, sweep_pos_nxt;
  logic                  gap_phase_r, gap_phase_nxt;
  logic                  out_valid_r;
  logic [LAMP_COUNT-1:0] out_led_r;
  logic [MODE_W-1:0]     out_mode_r;
  logic                  advance;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sweep_on  <= RST_SWEEP_ON;
      cfg_r.sweep_gap <= RST_SWEEP_GAP;
      cfg_r.adv_half  <= RST_ADV_HALF;
      cfg_r.data_off  <= RST_DATA_OFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SWEEP_ON:  cfg_r.sweep_on  <= pwdata[CFG_W-1:0];
        REG_SWEEP_GAP: cfg_r.sweep_gap <= pwdata[CFG_W-1:0];
        REG_ADV_HALF:  cfg_r.adv_half  <= pwdata[CFG_W-1:0];
        REG_DATA_OFF:  cfg_r.data_off  <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SWEEP_ON:  prdata = DATA_W'(cfg_r.sweep_on);
      REG_SWEEP_GAP: prdata = DATA_W'(cfg_r.sweep_gap);
      REG_ADV_HALF:  prdata = DATA_W'(cfg_r.adv_half);
      REG_DATA_OFF:  prdata = DATA_W'(cfg_r.data_off);
      default:       prdata = '0;
    endcase
  end

  // the word in the input register moves on unless the result register is held
  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r  <= in_op;
      s1_now_r <= in_now;
    end
  end

  sls_core #(
    .LedCount  (LedCount),
    .TickWidth (TickWidth)
  ) u_core (
    .op            (s1_op_r),
    .now           (s1_now_r),
    .cfg           (cfg_r),
    .mode          (mode_r),
    .lamps         (lamps_r),
    .deadline      (deadline_r),
    .sweep_pos     (sweep_pos_r),
    .gap_phase     (gap_phase_r),
    .mode_nxt      (mode_nxt),
    .lamps_nxt     (lamps_nxt),
    .deadline_nxt  (deadline_nxt),
    .sweep_pos_nxt (sweep_pos_nxt),
    .gap_phase_nxt (gap_phase_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      lamps_r     <= INIT_LAMPS;
      deadline_r  <= '0;
      sweep_pos_r <= '0;
      gap_phase_r <= 1'b0;
    end else if (advance) begin
      mode_r      <= mode_nxt;
      lamps_r     <= lamps_nxt;
      deadline_r  <= deadline_nxt;
      sweep_pos_r <= sweep_pos_nxt;
      gap_phase_r <= gap_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led_r  <= lamps_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_pattern = out_led_r;
  assign out_mode        = out_mode_r;

endmodule

// ----- sv/sls_core.sv -----
// next-state logic of the sequencer for one word
module sls_core import sls_pkg::*; #(
  parameter int LedCount  = SLS_LED_COUNT,
  parameter int TickWidth = SLS_TICK_WIDTH,
  localparam int PosW     = $clog2(LedCount)
) (
  input  logic [OP_W-1:0]       op,
  input  logic [NOW_W-1:0]      now,
  input  sls_cfg_t              cfg,
  input  logic [MODE_W-1:0]     mode,
  input  logic [LAMP_COUNT-1:0] lamps,
  input  logic [TickWidth-1:0]  deadline,
  input  logic [PosW-1:0]       sweep_pos,
  input  logic                  gap_phase,
  output logic [MODE_W-1:0]     mode_nxt,
  output logic [LAMP_COUNT-1:0] lamps_nxt,
  output logic [TickWidth-1:0]  deadline_nxt,
  output logic [PosW-1:0]       sweep_pos_nxt,
  output logic                  gap_phase_nxt
);

  logic [TickWidth-1:0]  now_t;
  logic [TickWidth-1:0]  diff;
  logic                  due;
  logic [CFG_W-1:0]      inc;
  logic [TickWidth-1:0]  later;
  logic [LAMP_COUNT-1:0] pos_bit;
  logic                  last_pos;

  assign now_t    = TickWidth'(now);
  assign diff     = now_t - deadline;
  assign due      = ~diff[TickWidth-1];
  assign pos_bit  = (sweep_pos < PosW'(LAMP_COUNT)) ? (LAMP_COUNT'(1) << sweep_pos) : '0;
  assign last_pos = (sweep_pos == PosW'(LedCount - 1));

  // one shared adder for every deadline update that adds an interval to now
  always_comb begin
    if (op == OP_TICK) begin
      if (mode == M_ADV) begin
        inc = cfg.adv_half;
      end else if (gap_phase) begin
        inc = cfg.sweep_gap;
      end else begin
        inc = cfg.sweep_on;
      end
    end else begin
      inc = cfg.data_off;
    end
  end

  assign later = now_t + TickWidth'(inc);

  always_comb begin
    logic [LAMP_COUNT-1:0] l;
    l             = lamps;
    mode_nxt      = mode;
    deadline_nxt  = deadline;
    sweep_pos_nxt = sweep_pos;
    gap_phase_nxt = gap_phase;
    case (op)
      OP_TICK: begin
        if (due) begin
          case (mode)
            M_ADV: begin
              if (!gap_phase) begin
                l = l & ~BT_BIT;
              end else begin
                l = l | BT_BIT;
              end
              gap_phase_nxt = ~gap_phase;
              deadline_nxt  = later;
            end
            M_SWEEP, M_UPDATE: begin
              deadline_nxt = later;
              if (!gap_phase) begin
                l             = l | pos_bit;
                gap_phase_nxt = 1'b1;
              end else begin
                l             = (l & ~pos_bit) | PWR_BIT;
                gap_phase_nxt = 1'b0;
                if (last_pos) begin
                  sweep_pos_nxt = '0;
                  // connect sweep ends after one pass, update sweep loops
                  if (mode == M_SWEEP) begin
                    mode_nxt = M_CONN;
                    l        = CONN_LAMPS;
                  end
                end else begin
                  sweep_pos_nxt = sweep_pos + PosW'(1);
                end
              end
            end
            M_DATA: begin
              l        = l | BT_BIT;
              mode_nxt = M_CONN;
            end
            default: begin
            end
          endcase
        end
      end
      OP_ADV, OP_DISCONNECT: begin
        mode_nxt      = M_ADV;
        l             = ADV_LAMPS;
        gap_phase_nxt = 1'b1;
        deadline_nxt  = now_t;
      end
      OP_CONNECT: begin
        if (mode != M_SWEEP) begin
          mode_nxt      = M_SWEEP;
          l             = PWR_BIT;
          sweep_pos_nxt = '0;
          gap_phase_nxt = 1'b0;
          deadline_nxt  = now_t;
        end
      end
      OP_DATA: begin
        if (mode == M_CONN) begin
          mode_nxt     = M_DATA;
          l            = l & ~BT_BIT;
          deadline_nxt = later;
        end else if (mode == M_DATA) begin
          deadline_nxt = later;
        end
      end
      OP_UPD_START: begin
        mode_nxt      = M_UPDATE;
        l             = PWR_BIT;
        sweep_pos_nxt = '0;
        gap_phase_nxt = 1'b0;
        deadline_nxt  = now_t;
      end
      OP_UPD_DONE: begin
        mode_nxt = M_CONN;
        l        = CONN_LAMPS;
      end
      default: begin
      end
    endcase
    // power lamp is never turned off
    lamps_nxt = l | PWR_BIT;
  end

endmodule

// ----- sv/sls_checker.sv -----
// port-level checks for the status led sequencer, bound to the top level
module sls_checker import sls_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [LAMP_COUNT-1:0] out_led_pattern,
  input logic [MODE_W-1:0]     out_mode
);

  // a held result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // power lamp is lit in every result word
  a_pwr_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_led_pattern[1])
    else $error("power lamp off in result word");

  // connected mode always shows the full connected pattern
  a_conn_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == M_CONN |-> out_led_pattern == CONN_LAMPS)
    else $error("connected mode with wrong lamp pattern");

  // bt lamp is dark through a data blink
  a_data_bt_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode == M_DATA |-> !out_led_pattern[3])
    else $error("bt lamp lit during data blink");

endmodule

bind status_led_sequencer sls_checker u_sls_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_led_pattern (out_led_pattern),
  .out_mode        (out_mode)
);
